[sv/extent_bitmap_allocator_unit_defines.svh]
// Assertion macros used by the allocator's top-level RTL file.
`ifndef EXTENT_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define EXTENT_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH

// Condition a holds, so condition b holds in the same cycle.
`define EBA_ASSERT_SAME(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Condition a holds, so condition b holds in the following cycle.
`define EBA_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

[sv/eba_pkg.sv]
`default_nettype none
package eba_pkg;

    // Map geometry.
    localparam int GROUP_COUNT = 32;
    localparam int IDX_W = $clog2(GROUP_COUNT);
    localparam int POS_W = $clog2(GROUP_COUNT + 1);
    localparam int K_W = 9;
    localparam int CNT_W = (POS_W > K_W) ? POS_W : K_W;

    // Configuration register indexes (word address bit).
    localparam logic REG_DATA_START = 1'b0;
    localparam logic [15:0] DATA_START_RESET = 16'd258;

    // Request modes.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_EXTEND = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [15:0] request_bytes;
        logic [15:0] extent_end_block;
    } t_req;

    typedef struct packed {
        logic        success;
        logic [15:0] start_block;
        logic [8:0]  added_blocks;
        logic [13:0] granted_bytes;
    } t_rsp;

    // Search token handed from cell to cell: run length in allocate mode,
    // groups still wanted in extend mode.
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] cnt;
    } t_tok;

    // Controls broadcast to every cell.
    typedef struct packed {
        logic             mode;
        logic [CNT_W-1:0] k;
        logic             inj;
        logic [IDX_W-1:0] inj_idx;
        t_tok             inj_tok;
        logic             mark;
        logic [IDX_W-1:0] mark_first;
        logic [IDX_W-1:0] mark_last;
    } t_ctl;

endpackage
`default_nettype wire

[sv/eba_cell.sv]
`default_nettype none
module eba_cell import eba_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire t_ctl             i_ctl,
    input  wire t_tok             i_tok,
    output t_tok                  o_tok,
    output logic                  o_hit
);

    logic r_used;
    logic n_used;
    t_tok r_tok;
    t_tok n_tok;
    t_tok tin;
    logic [CNT_W-1:0] run;
    logic ext_mark;
    logic rng_mark;

    // The token enters here when the controller injects it at this index.
    always_comb begin
        tin = (i_ctl.inj && (i_ctl.inj_idx == i_idx)) ? i_ctl.inj_tok : i_tok;
        run = r_used ? '0 : tin.cnt + CNT_W'(1);
        ext_mark = 1'b0;
        o_hit = 1'b0;
        n_tok = '0;
        if (i_ctl.mode == MODE_EXTEND) begin
            // Claim this group while it is free and groups are still wanted.
            o_hit = tin.valid && (r_used || (tin.cnt == '0));
            ext_mark = tin.valid && !r_used && (tin.cnt != '0);
            n_tok.cnt = tin.cnt - CNT_W'(1);
        end else begin
            // The run of free groups reaches the request size here.
            o_hit = tin.valid && !r_used && (run == i_ctl.k);
            n_tok.cnt = run;
        end
        n_tok.valid = tin.valid && !o_hit;
        rng_mark = i_ctl.mark && (i_idx >= i_ctl.mark_first) && (i_idx <= i_ctl.mark_last);
        n_used = r_used | ext_mark | rng_mark;
    end

    // Flag and token registers; group 0 starts out used.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= (i_idx == '0);
            r_tok <= '0;
        end else begin
            r_used <= n_used;
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

[sv/eba_chain.sv]
`default_nettype none
module eba_chain import eba_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_ctl i_ctl,
    output logic      o_hit,
    output logic      o_end
);

    t_tok tok [GROUP_COUNT+1];
    logic [GROUP_COUNT-1:0] hit;

    assign tok[0] = '0;

    // One cell per group, each passing the token to the next.
    for (genvar g = 0; g < GROUP_COUNT; g++) begin : g_cell
        eba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_ctl   (i_ctl),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .o_hit   (hit[g])
        );
    end

    // Only one token is ever live, so a plain OR finds its stop.
    assign o_hit = |hit;
    assign o_end = tok[GROUP_COUNT].valid;

endmodule
`default_nettype wire

[sv/extent_bitmap_allocator_unit.sv]
// Channel  | Ports                          | Handshake
// ---------+--------------------------------+--------------------------------
// Request  | start, busy, i_req             | beat when start high, busy low
// Result   | o_done, o_rsp                  | beat on each cycle o_done high
// Config   | psel, penable, pwrite, paddr,  | write when psel, penable,
//          | pwdata, prdata, pready         | pwrite, pready high
//
// A search token walks the row of group cells, one cell per cycle. An
// allocate ends when a free run reaches the request size or the token runs
// past the last group; an extend ends at the first used group, when no more
// groups are wanted, or past the last group. A zero allocate or a bad extent
// end answers in the cycle after accept.
// Reset clears the map to group 0 used and the start block to 258.
// The result strobe lasts one cycle; the receiver cannot stall it.
`default_nettype none
`include "extent_bitmap_allocator_unit_defines.svh"
module extent_bitmap_allocator_unit import eba_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_req        i_req,
    output logic             o_done,
    output t_rsp             o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state r_state, n_state;
    logic [15:0] r_dsb, n_dsb;
    logic r_mode, n_mode;
    logic [K_W-1:0] r_k, n_k;
    logic [IDX_W-1:0] r_g0, n_g0;
    logic [POS_W-1:0] r_pos, n_pos;
    logic r_inj, n_inj;
    t_tok r_inj_tok, n_inj_tok;
    logic r_mark, n_mark;
    logic [IDX_W-1:0] r_first, n_first;
    logic [IDX_W-1:0] r_last, n_last;
    logic r_done, n_done;
    t_rsp r_rsp, n_rsp;

    t_ctl ctl;
    logic hit;
    logic at_end;
    logic [16:0] sum;
    logic [K_W-1:0] k;
    logic [16:0] diff;
    logic bad_end;
    logic [CNT_W-1:0] fpos;
    logic [POS_W-1:0] added;

    function automatic t_rsp answer(input logic ok, input logic [15:0] sb,
                                    input logic [15:0] groups);
        t_rsp r;
        r.success = ok;
        r.start_block = sb;
        r.added_blocks = 9'({groups, 3'b000});
        r.granted_bytes = 14'({groups, 8'h00});
        return r;
    endfunction

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DATA_START) ? {16'h0000, r_dsb} : 32'h0000_0000;
    assign busy = (r_state != ST_IDLE);

    // Broadcast controls for the cell row.
    always_comb begin
        ctl.mode = r_mode;
        ctl.k = CNT_W'(r_k);
        ctl.inj = r_inj;
        ctl.inj_idx = r_g0;
        ctl.inj_tok = r_inj_tok;
        ctl.mark = r_mark;
        ctl.mark_first = r_first;
        ctl.mark_last = r_last;
    end

    eba_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_hit   (hit),
        .o_end   (at_end)
    );

    // Request decode: group count and the group that holds the extent end.
    always_comb begin
        sum = {1'b0, i_req.request_bytes} + 17'd255;
        k = sum[16:8];
        diff = {1'b0, i_req.extent_end_block} - {1'b0, r_dsb};
        bad_end = diff[16] || (diff[15:3] >= 13'(GROUP_COUNT));
        fpos = CNT_W'(r_pos) + CNT_W'(1) - CNT_W'(r_k);
        added = r_pos - POS_W'(r_g0);
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_dsb = r_dsb;
        n_mode = r_mode;
        n_k = r_k;
        n_g0 = r_g0;
        n_pos = r_pos;
        n_inj = 1'b0;
        n_inj_tok = r_inj_tok;
        n_mark = 1'b0;
        n_first = r_first;
        n_last = r_last;
        n_done = 1'b0;
        n_rsp = r_rsp;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_DATA_START)) begin
            n_dsb = pwdata[15:0];
        end
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_mode = i_req.mode;
                    n_k = k;
                    if (i_req.mode == MODE_ALLOC) begin
                        if (k == '0) begin
                            n_done = 1'b1;
                            n_rsp = answer(1'b1, r_dsb, 16'h0000);
                        end else begin
                            n_g0 = '0;
                            n_pos = '0;
                            n_inj = 1'b1;
                            n_inj_tok = '{valid: 1'b1, cnt: '0};
                            n_state = ST_SCAN;
                        end
                    end else begin
                        if (bad_end) begin
                            n_done = 1'b1;
                            n_rsp = answer(1'b0, 16'h0000, 16'h0000);
                        end else begin
                            n_g0 = diff[IDX_W+2:3];
                            n_pos = POS_W'(diff[IDX_W+2:3]);
                            n_inj = 1'b1;
                            n_inj_tok = '{valid: 1'b1, cnt: CNT_W'(k)};
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (hit || at_end) begin
                    n_done = 1'b1;
                    n_state = ST_IDLE;
                    if (r_mode == MODE_EXTEND) begin
                        n_rsp = answer(1'b1, 16'h0000, 16'(added));
                    end else if (hit) begin
                        // Claim the run in one pass over the row.
                        n_mark = 1'b1;
                        n_first = fpos[IDX_W-1:0];
                        n_last = r_pos[IDX_W-1:0];
                        n_rsp = answer(1'b1, r_dsb + 16'({fpos[IDX_W-1:0], 3'b000}),
                                       16'(r_k));
                    end else begin
                        n_rsp = answer(1'b0, 16'h0000, 16'h0000);
                    end
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dsb <= DATA_START_RESET;
            r_inj <= 1'b0;
            r_mark <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dsb <= n_dsb;
            r_inj <= n_inj;
            r_mark <= n_mark;
            r_done <= n_done;
        end
        r_mode <= n_mode;
        r_k <= n_k;
        r_g0 <= n_g0;
        r_pos <= n_pos;
        r_inj_tok <= n_inj_tok;
        r_first <= n_first;
        r_last <= n_last;
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp = r_rsp;

    // Checks on the sequencer.
    `EBA_ASSERT_NEXT(a_accept_moves, i_clk, i_rst_n, start && !busy, busy || o_done, "accepted request neither searched nor answered")
    `EBA_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result beat while still searching")
    `EBA_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, o_done && !o_rsp.success, (o_rsp.added_blocks == 9'd0) && (o_rsp.start_block == 16'h0000), "failed result carries a grant")
    `EBA_ASSERT_NEXT(a_mark_once, i_clk, i_rst_n, r_mark, !r_mark, "claim pulse held for more than one cycle")

endmodule
`default_nettype wire
